// ===== rtl/olpe_pkg.sv =====
// Shared types and constants of the ordered list with positional edit.
package olpe_pkg;

  localparam int CAPACITY = 16;
  localparam int KIND_W   = 2;
  localparam int POS_W    = 6;
  localparam int WORD_W   = 32;
  localparam int COUNT_W  = 5;
  localparam int CMP_W    = ((COUNT_W > POS_W) ? COUNT_W : POS_W) + 1;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_SEARCH = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_FROM_LEFT  = 2'd2,
    CELL_FROM_RIGHT = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     match_en;
  } cell_ctrl_t;

endpackage

// ===== rtl/olpe_req_if.sv =====
// Request channel carrying one list operation word.
interface olpe_req_if;
  import olpe_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [POS_W-1:0]    position;
  logic signed [WORD_W-1:0] value;

  modport source(output valid, output kind, output position, output value, input ready);
  modport sink(input valid, input kind, input position, input value, output ready);
endinterface

// ===== rtl/olpe_rsp_if.sv =====
// Response channel carrying one operation result word.
interface olpe_rsp_if;
  import olpe_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               found;
  logic [COUNT_W-1:0] count;

  modport source(output valid, output status, output found, output count, input ready);
  modport sink(input valid, input status, input found, input count, output ready);
endinterface

// ===== rtl/olpe_cell.sv =====
// One list cell: holds an entry, shifts with its neighbors and compares against the key.
module olpe_cell import olpe_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  word_t      load_value,
  input  word_t      left_data,
  input  word_t      right_data,
  input  word_t      key,
  output word_t      data,
  output logic       match
);

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      CELL_HOLD:       data <= data;
      CELL_LOAD:       data <= load_value;
      CELL_FROM_LEFT:  data <= left_data;
      CELL_FROM_RIGHT: data <= right_data;
      default:         data <= data;
    endcase
  end

  assign match = ctrl.match_en && (data == key);

endmodule

// ===== rtl/olpe_chain.sv =====
// Row of list cells with the per-cell shift and compare control.
module olpe_chain import olpe_pkg::*; (
  input  logic               clk,
  input  logic               do_insert,
  input  logic               do_delete,
  input  logic [POS_W-1:0]   position,
  input  logic [COUNT_W-1:0] count,
  input  word_t              value,
  output logic               hit
);

  word_t                  cell_data [CAPACITY];
  logic [CAPACITY-1:0]    cell_match;
  cell_ctrl_t             cell_ctrl [CAPACITY];
  logic [CMP_W-1:0]       target;
  logic [CMP_W-1:0]       count_w;

  assign target  = CMP_W'(position) - CMP_W'(1);
  assign count_w = CMP_W'(count);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_comb begin
      cell_ctrl[i].match_en = CMP_W'(i) < count_w;
      priority if (do_insert && (CMP_W'(i) > target)) begin
        cell_ctrl[i].op = CELL_FROM_LEFT;
      end else if (do_insert && (CMP_W'(i) == target)) begin
        cell_ctrl[i].op = CELL_LOAD;
      end else if (do_delete && (CMP_W'(i) >= target)) begin
        cell_ctrl[i].op = CELL_FROM_RIGHT;
      end else begin
        cell_ctrl[i].op = CELL_HOLD;
      end
    end

    olpe_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .load_value (value),
      .left_data  ((i == 0) ? value : cell_data[(i == 0) ? 0 : i - 1]),
      .right_data (cell_data[(i == CAPACITY - 1) ? i : i + 1]),
      .key        (value),
      .data       (cell_data[i]),
      .match      (cell_match[i])
    );
  end

  assign hit = |cell_match;

endmodule

// ===== rtl/ordered_list_positional_edit.sv =====
// Top level of the bounded ordered list with positional insert, delete and search.
// For each request word accepted, a row of 16 cells shifts or compares every
// entry at once, and the result word is registered and offered in the following
// cycle. A new request is taken in the same cycle the pending result is taken, so
// the block sustains one operation per cycle when the response side keeps up.
module ordered_list_positional_edit import olpe_pkg::*; (
  input logic          clk,
  input logic          rst,
  olpe_req_if.sink     req,
  olpe_rsp_if.source   rsp
);

  logic               accept;
  logic [COUNT_W-1:0] count_q;
  logic [COUNT_W-1:0] count_next;
  status_t            status_next;
  logic               found_next;
  logic               do_insert;
  logic               do_delete;
  logic               hit;
  logic [CMP_W-1:0]   pos_w;
  logic [CMP_W-1:0]   cnt_w;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign pos_w     = CMP_W'(req.position);
  assign cnt_w     = CMP_W'(count_q);

  always_comb begin
    status_next = ST_OK;
    found_next  = 1'b0;
    count_next  = count_q;
    do_insert   = 1'b0;
    do_delete   = 1'b0;
    unique case (req.kind)
      KIND_INSERT: begin
        priority if (cnt_w >= CMP_W'(CAPACITY)) begin
          status_next = ST_FULL;
        end else if ((pos_w == '0) || (pos_w > cnt_w + CMP_W'(1))) begin
          status_next = ST_BADPOS;
        end else begin
          do_insert  = accept;
          count_next = count_q + COUNT_W'(1);
        end
      end
      KIND_DELETE: begin
        priority if (count_q == '0) begin
          status_next = ST_EMPTY;
        end else if ((pos_w == '0) || (pos_w > cnt_w)) begin
          status_next = ST_BADPOS;
        end else begin
          do_delete  = accept;
          count_next = count_q - COUNT_W'(1);
        end
      end
      KIND_SEARCH: begin
        if (count_q == '0) begin
          status_next = ST_EMPTY;
        end else begin
          found_next = hit;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  olpe_chain u_chain (
    .clk       (clk),
    .do_insert (do_insert),
    .do_delete (do_delete),
    .position  (req.position),
    .count     (count_q),
    .value     (req.value),
    .hit       (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count_q   <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        count_q   <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status <= status_next;
      rsp.found  <= found_next;
      rsp.count  <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(count_q) <= CMP_W'(CAPACITY))
    else $error("List count exceeds capacity.");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp.valid)
    else $error("Accepted request produced no result.");

  a_count_idle_stable: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(count_q))
    else $error("List count changed without a request.");

  a_result_count_matches: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.count == count_q))
    else $error("Reported count differs from held count.");

  a_failed_edit_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (accept && (status_next != ST_OK)) |=> (count_q == $past(count_q)))
    else $error("Rejected operation changed the count.");

endmodule
